// ===== design/mjst_pkg.sv =====
// shared types, constants and microcode for the min-jerk servo trajectory block
`timescale 1ns / 1ps
`default_nettype none

package mjst_pkg;

    localparam int POS_WIDTH_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 16;

    // command codes on the input channel
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_MS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FLOOR  = 2'd3;

    localparam logic [7:0] TICK_MS_RESET = 8'd20;

    // q16 polynomial arithmetic
    localparam int TAU_W     = 16;
    localparam int DIV_STEPS = TAU_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int AB_W      = 22;
    localparam int B_W       = 18;
    localparam logic signed [AB_W-1:0] K15_Q16 = AB_W'(15 * 65536);
    localparam logic signed [AB_W-1:0] K10_Q16 = AB_W'(10 * 65536);
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [7:0]         tick_ms;
        logic [11:0]        target_offset;
        logic               floor_enable;
        logic signed [15:0] target_floor;
    } t_cfg;

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_MUL_TT,
        UOP_MUL_T2,
        UOP_SET_A,
        UOP_MUL_A,
        UOP_SET_B,
        UOP_MUL_B,
        UOP_SET_S,
        UOP_MUL_S,
        UOP_EMIT_MOVE,
        UOP_EMIT_GOAL,
        UOP_NOP
    } t_uop;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GO,
        COND_FIN,
        COND_LOOP,
        COND_WAIT,
        COND_JUMP
    } t_cond;

    localparam int PC_W = 4;

    typedef struct packed {
        t_uop            op;
        t_cond           cond;
        logic [PC_W-1:0] tgt;
    } t_ctrl;

    typedef struct packed {
        logic go;
        logic fin;
        logic out_free;
    } t_stat;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
    localparam logic [PC_W-1:0] PC_DIV   = 4'd2;
    localparam logic [PC_W-1:0] PC_MTT   = 4'd3;
    localparam logic [PC_W-1:0] PC_MT2   = 4'd4;
    localparam logic [PC_W-1:0] PC_SETA  = 4'd5;
    localparam logic [PC_W-1:0] PC_MA    = 4'd6;
    localparam logic [PC_W-1:0] PC_SETB  = 4'd7;
    localparam logic [PC_W-1:0] PC_MB    = 4'd8;
    localparam logic [PC_W-1:0] PC_SETS  = 4'd9;
    localparam logic [PC_W-1:0] PC_MS    = 4'd10;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd11;
    localparam logic [PC_W-1:0] PC_FIN   = 4'd12;

    // control store
    function automatic t_ctrl urom(input logic [PC_W-1:0] pc);
        t_ctrl w;
        unique case (pc)
            PC_IDLE:  w = '{op: UOP_IDLE,      cond: COND_GO,   tgt: PC_CHECK};
            PC_CHECK: w = '{op: UOP_DIV_INIT,  cond: COND_FIN,  tgt: PC_FIN};
            PC_DIV:   w = '{op: UOP_DIV_STEP,  cond: COND_LOOP, tgt: PC_DIV};
            PC_MTT:   w = '{op: UOP_MUL_TT,    cond: COND_NEXT, tgt: PC_IDLE};
            PC_MT2:   w = '{op: UOP_MUL_T2,    cond: COND_NEXT, tgt: PC_IDLE};
            PC_SETA:  w = '{op: UOP_SET_A,     cond: COND_NEXT, tgt: PC_IDLE};
            PC_MA:    w = '{op: UOP_MUL_A,     cond: COND_NEXT, tgt: PC_IDLE};
            PC_SETB:  w = '{op: UOP_SET_B,     cond: COND_NEXT, tgt: PC_IDLE};
            PC_MB:    w = '{op: UOP_MUL_B,     cond: COND_NEXT, tgt: PC_IDLE};
            PC_SETS:  w = '{op: UOP_SET_S,     cond: COND_NEXT, tgt: PC_IDLE};
            PC_MS:    w = '{op: UOP_MUL_S,     cond: COND_NEXT, tgt: PC_IDLE};
            PC_EMIT:  w = '{op: UOP_EMIT_MOVE, cond: COND_WAIT, tgt: PC_IDLE};
            PC_FIN:   w = '{op: UOP_EMIT_GOAL, cond: COND_WAIT, tgt: PC_IDLE};
            default:  w = '{op: UOP_NOP,       cond: COND_JUMP, tgt: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/mjst_cmd_if.sv =====
// command channel: tick or move words into the trajectory block
`timescale 1ns / 1ps
`default_nettype none

interface mjst_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] cmd_angle;
    logic [15:0]        duration_ms;

    modport source (output valid, output opcode, output cmd_angle, output duration_ms,
                    input ready);
    modport sink   (input valid, input opcode, input cmd_angle, input duration_ms,
                    output ready);
endinterface

`default_nettype wire

// ===== design/mjst_res_if.sv =====
// result channel: servo angle words out of the trajectory block
`timescale 1ns / 1ps
`default_nettype none

interface mjst_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle;
    logic               done_res;

    modport source (output valid, output angle, output done_res, input ready);
    modport sink   (input valid, input angle, input done_res, output ready);
endinterface

`default_nettype wire

// ===== design/min_jerk_servo_trajectory.sv =====
// min-jerk servo trajectory: configuration registers, sequencer and datapath
//
// i_cmd takes one word at a time: opcode CMD_MOVE loads a new goal and duration,
// CMD_TICK, while a move runs, advances elapsed time by tick_ms and yields one
// angle word on o_res (done_res set on the word that finishes the move).
// A move word, or a tick with no move running, is accepted at the idle step and gives no word.
// A finishing tick goes through accept, completion check, goal out.
// Any other tick goes from accept to the word on o_res through: check,
// 16 steps of the one-bit-per-cycle restoring divider for tau, 8 steps on the
// single shared multiplier for the quintic blend, then output load.
// i_cmd.ready is high only while the sequencer sits at its idle step.
// The result sits in an output register, so the next word is accepted while it
// waits; if o_res stalls, the emit step holds until the register frees up.
// Synchronous reset returns to idle with start, goal, duration and elapsed at
// zero, tick_ms at 20 and the offset, floor enable and floor at zero.
// Config writes via i_cfg_we/i_cfg_idx/i_cfg_data take effect on the next edge.
`timescale 1ns / 1ps
`default_nettype none

module min_jerk_servo_trajectory import mjst_pkg::*; #(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mjst_cmd_if.sink              i_cmd,
    mjst_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_ctrl ctrl;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_ms       <= TICK_MS_RESET;
            r_cfg.target_offset <= '0;
            r_cfg.floor_enable  <= 1'b0;
            r_cfg.target_floor  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TICK_MS:       r_cfg.tick_ms       <= i_cfg_data[7:0];
                REG_TARGET_OFFSET: r_cfg.target_offset <= i_cfg_data[11:0];
                REG_FLOOR_ENABLE:  r_cfg.floor_enable  <= i_cfg_data[0];
                REG_TARGET_FLOOR:  r_cfg.target_floor  <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    mjst_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    mjst_dpath #(
        .POS_WIDTH  (POS_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctrl  (ctrl),
        .o_stat  (stat),
        .i_cmd   (i_cmd),
        .o_res   (o_res)
    );

    // words are only taken while the sequencer is parked
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |-> (ctrl.op == UOP_IDLE))
        else $error("command word accepted while sequencer busy");

    // a running tick always enters the completion check next
    a_go_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.go |=> (ctrl.op == UOP_DIV_INIT))
        else $error("tick did not start the program");

    // emit step holds while the output register is full
    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((ctrl.op == UOP_EMIT_MOVE) || (ctrl.op == UOP_EMIT_GOAL)) && !stat.out_free)
        |=> (ctrl.op == $past(ctrl.op)))
        else $error("emit step left before output register freed");

    // a completed emit shows up on the result channel
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((ctrl.op == UOP_EMIT_MOVE) || (ctrl.op == UOP_EMIT_GOAL)) && stat.out_free)
        |=> o_res.valid)
        else $error("emitted word not presented on result channel");

endmodule

`default_nettype wire

// ===== design/mjst_useq.sv =====
// microcode sequencer: step counter, control store fetch and conditional jumps
`timescale 1ns / 1ps
`default_nettype none

module mjst_useq import mjst_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_ctrl            ctrl;
    logic             loop_last;

    assign ctrl      = urom(r_pc);
    assign o_ctrl    = ctrl;
    assign loop_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        unique case (ctrl.cond)
            COND_NEXT: n_pc = r_pc + PC_W'(1);
            COND_GO:   n_pc = i_stat.go ? ctrl.tgt : r_pc;
            COND_FIN:  n_pc = i_stat.fin ? ctrl.tgt : r_pc + PC_W'(1);
            COND_LOOP: n_pc = loop_last ? r_pc + PC_W'(1) : ctrl.tgt;
            COND_WAIT: n_pc = i_stat.out_free ? ctrl.tgt : r_pc;
            COND_JUMP: n_pc = ctrl.tgt;
            default:   n_pc = PC_IDLE;
        endcase
        // quotient bit counter runs only inside the divide loop
        n_cnt = (ctrl.op == UOP_DIV_STEP) ? r_cnt + CNT_W'(1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= PC_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/mjst_dpath.sv =====
// datapath: move state, restoring divider, shared multiplier and output register
`timescale 1ns / 1ps
`default_nettype none

module mjst_dpath import mjst_pkg::*; #(
    parameter int POS_WIDTH  = POS_WIDTH_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_ctrl i_ctrl,
    output t_stat o_stat,
    mjst_cmd_if.sink   i_cmd,
    mjst_res_if.source o_res
);

    localparam int MA_W = (POS_WIDTH + 1 > AB_W) ? POS_WIDTH + 1 : AB_W;
    localparam int PW   = MA_W + B_W;
    localparam int GW   = (POS_WIDTH + 1 > 18) ? POS_WIDTH + 1 : 18;
    localparam int DW   = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

    localparam logic signed [GW-1:0] PMAX = GW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
    localparam logic signed [GW-1:0] PMIN = ~PMAX;
    localparam logic [DW-1:0] TMAX = DW'((64'd1 << TIME_WIDTH) - 64'd1);
    localparam logic [TIME_WIDTH+1:0] EMAX =
        (TIME_WIDTH + 2)'((64'd1 << (TIME_WIDTH + 1)) - 64'd1);
    localparam logic signed [PW-17:0] S_ONE = (PW - 16)'(ONE_Q16);

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [GW-1:0] v);
        logic signed [POS_WIDTH-1:0] sv;
        if (v > PMAX) begin
            sv = PMAX[POS_WIDTH-1:0];
        end else if (v < PMIN) begin
            sv = PMIN[POS_WIDTH-1:0];
        end else begin
            sv = v[POS_WIDTH-1:0];
        end
        return sv;
    endfunction

    // architectural state
    logic signed [POS_WIDTH-1:0] r_start;
    logic signed [POS_WIDTH-1:0] r_goal;
    logic [TIME_WIDTH-1:0]       r_mt;
    logic [TIME_WIDTH:0]         r_elapsed;
    logic                        r_moving;

    // working registers
    logic [TIME_WIDTH-1:0]       r_rem;
    logic [TAU_W-1:0]            r_tau;
    logic [15:0]                 r_t;
    logic signed [AB_W-1:0]      r_ab;
    logic [16:0]                 r_s;
    logic signed [POS_WIDTH:0]   r_diff;
    logic signed [PW-1:0]        r_prod;

    logic                        r_o_valid;
    logic signed [15:0]          r_o_angle;
    logic                        r_o_done;

    logic                        acc;
    logic                        is_move;
    logic                        go;
    logic                        fin;
    logic                        out_free;
    logic                        emit;

    logic signed [17:0]          g_raw;
    logic signed [POS_WIDTH-1:0] g_sat;
    logic signed [POS_WIDTH-1:0] f_sat;
    logic signed [POS_WIDTH-1:0] goal_new;
    logic [DW-1:0]               dur_x;
    logic [DW-1:0]               dur_sat;
    logic [TIME_WIDTH+1:0]       e_sum;
    logic [TIME_WIDTH:0]         e_new;

    logic [TIME_WIDTH:0]         rem2;
    logic [TIME_WIDTH:0]         mt_x;
    logic                        q_bit;
    logic [TIME_WIDTH:0]         rem_sub;

    logic signed [MA_W-1:0]      mul_a;
    logic signed [B_W-1:0]       mul_b;
    logic signed [PW-1:0]        prod;

    logic signed [AB_W-1:0]      a_val;
    logic signed [AB_W-1:0]      b_val;
    logic signed [PW-17:0]       s_full;
    logic [16:0]                 s_val;
    logic signed [POS_WIDTH:0]   diff_val;
    logic signed [POS_WIDTH:0]   pos_move;
    logic signed [POS_WIDTH-1:0] pos_emit;
    logic signed [POS_WIDTH+15:0] pos_x;

    assign i_cmd.ready = (i_ctrl.op == UOP_IDLE);
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign is_move     = acc && (i_cmd.opcode == CMD_MOVE);
    assign go          = acc && (i_cmd.opcode == CMD_TICK) && r_moving;
    assign fin         = (r_mt == '0) || (r_elapsed >= (TIME_WIDTH + 1)'(r_mt));
    assign out_free    = !r_o_valid || o_res.ready;
    assign emit        = ((i_ctrl.op == UOP_EMIT_MOVE) || (i_ctrl.op == UOP_EMIT_GOAL))
                         && out_free;
    assign o_stat      = '{go: go, fin: fin, out_free: out_free};

    // goal and duration of a new move, and elapsed time after a tick
    always_comb begin
        g_raw    = 18'(i_cmd.cmd_angle) - $signed({6'd0, i_cfg.target_offset});
        g_sat    = sat_pos(GW'(g_raw));
        f_sat    = sat_pos(GW'($signed(i_cfg.target_floor)));
        goal_new = (i_cfg.floor_enable && (g_sat < f_sat)) ? f_sat : g_sat;
        dur_x    = DW'(i_cmd.duration_ms);
        dur_sat  = (dur_x > TMAX) ? TMAX : dur_x;
        e_sum    = (TIME_WIDTH + 2)'(r_elapsed) + (TIME_WIDTH + 2)'(i_cfg.tick_ms);
        e_new    = (e_sum > EMAX) ? EMAX[TIME_WIDTH:0] : e_sum[TIME_WIDTH:0];
    end

    // one quotient bit of elapsed * 2^16 / move_time per step
    always_comb begin
        rem2    = {r_rem, 1'b0};
        mt_x    = {1'b0, r_mt};
        q_bit   = (rem2 >= mt_x);
        rem_sub = rem2 - mt_x;
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctrl.op)
            UOP_MUL_TT: begin
                mul_a = MA_W'(r_tau);
                mul_b = B_W'(r_tau);
            end
            UOP_MUL_T2: begin
                mul_a = MA_W'(r_prod[31:16]);
                mul_b = B_W'(r_tau);
            end
            UOP_MUL_A: begin
                mul_a = MA_W'(r_ab);
                mul_b = B_W'(r_tau);
            end
            UOP_MUL_B: begin
                mul_a = MA_W'(r_ab);
                mul_b = B_W'(r_t);
            end
            UOP_MUL_S: begin
                mul_a = MA_W'(r_diff);
                mul_b = B_W'(r_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    // post-product arithmetic, floors are arithmetic shifts
    always_comb begin
        a_val    = $signed(AB_W'({r_tau, 2'b00})) + $signed(AB_W'({r_tau, 1'b0})) - K15_Q16;
        b_val    = $signed(r_prod[AB_W+15:16]) + K10_Q16;
        s_full   = $signed(r_prod[PW-1:16]);
        if (s_full < 0) begin
            s_val = '0;
        end else if (s_full > S_ONE) begin
            s_val = ONE_Q16;
        end else begin
            s_val = s_full[16:0];
        end
        diff_val = (POS_WIDTH + 1)'(r_goal) - (POS_WIDTH + 1)'(r_start);
        pos_move = (POS_WIDTH + 1)'(r_start) + $signed(r_prod[POS_WIDTH+16:16]);
        pos_emit = (i_ctrl.op == UOP_EMIT_GOAL) ? r_goal : pos_move[POS_WIDTH-1:0];
        pos_x    = (POS_WIDTH + 16)'(pos_emit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_goal    <= '0;
            r_mt      <= '0;
            r_elapsed <= '0;
            r_moving  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (is_move) begin
                r_goal   <= goal_new;
                r_mt     <= dur_sat[TIME_WIDTH-1:0];
                r_moving <= 1'b1;
            end
            if (go) begin
                r_elapsed <= e_new;
            end
            if (emit && (i_ctrl.op == UOP_EMIT_GOAL)) begin
                r_start   <= r_goal;
                r_elapsed <= '0;
                r_moving  <= 1'b0;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op) inside
            UOP_DIV_INIT: begin
                r_rem <= r_elapsed[TIME_WIDTH-1:0];
            end
            UOP_DIV_STEP: begin
                r_rem <= q_bit ? rem_sub[TIME_WIDTH-1:0] : rem2[TIME_WIDTH-1:0];
                r_tau <= {r_tau[TAU_W-2:0], q_bit};
            end
            UOP_MUL_TT, UOP_MUL_T2, UOP_MUL_A, UOP_MUL_B, UOP_MUL_S: begin
                r_prod <= prod;
            end
            UOP_SET_A: begin
                r_t  <= r_prod[31:16];
                r_ab <= a_val;
            end
            UOP_SET_B: begin
                r_ab <= b_val;
            end
            UOP_SET_S: begin
                r_s    <= s_val;
                r_diff <= diff_val;
            end
            default: begin
            end
        endcase
        if (emit) begin
            r_o_angle <= pos_x[15:0];
            r_o_done  <= (i_ctrl.op == UOP_EMIT_GOAL);
        end
    end

    assign o_res.valid    = r_o_valid;
    assign o_res.angle    = r_o_angle;
    assign o_res.done_res = r_o_done;

endmodule

`default_nettype wire
